// ===== hw/rtl/pss_pkg.sv =====
// Shared types and constants of the periodic stimulus scheduler.
package pss_pkg;

  // Request type codes
  localparam logic [1:0] REQ_TICK       = 2'd0;
  localparam logic [1:0] REQ_SET_PERIOD = 2'd1;
  localparam logic [1:0] REQ_SET_ACTIVE = 2'd2;

  // Fixed field widths
  localparam int unsigned MaskW       = 3;
  localparam int unsigned ValueW      = 31;
  localparam int unsigned StepW       = 32;
  localparam int unsigned StepMarkW   = 12;  // step modulo 4096 is the low 12 bits
  localparam int unsigned CfgAddrW    = 3;
  localparam int unsigned CfgDataW    = 32;

  // Register indexes
  localparam logic REG_RUN_ENABLE = 1'b0;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [1:0]        group;
    logic [ValueW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [MaskW-1:0] fire_mask;
    logic [MaskW-1:0] zero_period_mask;
    logic             bad_group;
    logic             step_mark;
  } res_t;

endpackage

// ===== hw/rtl/pss_if.sv =====
// Request and result channel interfaces of the scheduler.
interface pss_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [1:0]                    group;
  logic [pss_pkg::ValueW-1:0]    value;

  modport source (output valid, req_type, group, value, input ready);
  modport sink   (input valid, req_type, group, value, output ready);
endinterface

interface pss_res_if;
  logic                          valid;
  logic                          ready;
  logic [pss_pkg::MaskW-1:0]     fire_mask;
  logic [pss_pkg::MaskW-1:0]     zero_period_mask;
  logic                          bad_group;
  logic                          step_mark;

  modport source (output valid, fire_mask, zero_period_mask, bad_group, step_mark,
                  input ready);
  modport sink   (input valid, fire_mask, zero_period_mask, bad_group, step_mark,
                  output ready);
endinterface

// ===== hw/rtl/periodic_stimulus_scheduler_top.sv =====
// Periodic stimulus scheduler: input register, schedule core and result register.
// A request waits in the input register until the result register can take it.
// Throughput: one request per cycle if the sink keeps up (single-pass group update).
// Every request yields exactly one result, held until the sink takes it.
// Reset (rst_ni low, asynchronous) clears all groups, the step count and run enable.
module periodic_stimulus_scheduler_top #(
  parameter int unsigned NUM_GROUPS = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pss_req_if.sink                        req_ch,
  pss_res_if.source                      res_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pss_pkg::CfgAddrW-1:0]   paddr,
  input  logic [pss_pkg::CfgDataW-1:0]   pwdata,
  output logic [pss_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready
);

  logic           run_enable;
  logic           in_valid_q, in_valid_d;
  pss_pkg::req_t  in_req_q, in_req_d;
  logic           out_valid_q, out_valid_d;
  pss_pkg::res_t  out_res_q, out_res_d;
  pss_pkg::res_t  core_res;
  logic           advance;
  logic           in_ready;

  pss_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .run_enable_o (run_enable)
  );

  // The held request moves on when the result register is free or being emptied.
  assign advance  = in_valid_q && (!out_valid_q || res_ch.ready);
  assign in_ready = !in_valid_q || advance;
  assign req_ch.ready = in_ready;

  pss_sched_core #(
    .NUM_GROUPS (NUM_GROUPS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .run_enable_i (run_enable),
    .commit_i     (advance),
    .req_i        (in_req_q),
    .res_o        (core_res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    in_req_d   = in_req_q;
    if (in_ready) begin
      in_valid_d        = req_ch.valid;
      in_req_d.req_type = req_ch.req_type;
      in_req_d.group    = req_ch.group;
      in_req_d.value    = req_ch.value;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_res_d   = core_res;
    end else if (res_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_req_q  <= in_req_d;
    out_res_q <= out_res_d;
  end

  assign res_ch.valid            = out_valid_q;
  assign res_ch.fire_mask        = out_res_q.fire_mask;
  assign res_ch.zero_period_mask = out_res_q.zero_period_mask;
  assign res_ch.bad_group        = out_res_q.bad_group;
  assign res_ch.step_mark        = out_res_q.step_mark;

endmodule

// ===== hw/rtl/pss_cfg_regs.sv =====
// APB configuration register block holding the run enable flag.
module pss_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pss_pkg::CfgAddrW-1:0]   paddr,
  input  logic [pss_pkg::CfgDataW-1:0]   pwdata,
  output logic [pss_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready,
  output logic                           run_enable_o
);

  logic run_enable_q, run_enable_d;
  logic reg_idx;
  logic wr_en;

  // Registers sit on 4-byte boundaries, so bit 2 selects the register.
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready && (reg_idx == pss_pkg::REG_RUN_ENABLE);

  always_comb begin
    run_enable_d = run_enable_q;
    if (wr_en) begin
      run_enable_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_enable_q <= 1'b0;
    end else begin
      run_enable_q <= run_enable_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      pss_pkg::REG_RUN_ENABLE: prdata = {{(pss_pkg::CfgDataW-1){1'b0}}, run_enable_q};
      default:                 prdata = '0;
    endcase
  end

  assign run_enable_o = run_enable_q;

endmodule

// ===== hw/rtl/pss_sched_core.sv =====
// Schedule state and the single-pass update for one request.
module pss_sched_core #(
  parameter int unsigned NUM_GROUPS = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            run_enable_i,
  input  logic            commit_i,
  input  pss_pkg::req_t   req_i,
  output pss_pkg::res_t   res_o
);

  localparam int unsigned StepW  = pss_pkg::StepW;
  localparam int unsigned ValueW = pss_pkg::ValueW;
  localparam int unsigned MaskW  = pss_pkg::MaskW;

  logic [NUM_GROUPS-1:0]  active_q, active_d;
  logic [ValueW-1:0]      period_q [NUM_GROUPS];
  logic [ValueW-1:0]      period_d [NUM_GROUPS];
  logic [StepW-1:0]       next_q   [NUM_GROUPS];
  logic [StepW-1:0]       next_d   [NUM_GROUPS];
  logic [StepW-1:0]       step_q, step_d;

  logic                   run_tick;
  logic                   set_req;
  logic                   group_ok;
  logic [StepW-1:0]       step_inc;
  logic [NUM_GROUPS-1:0]  fire_v;
  logic [NUM_GROUPS-1:0]  zero_v;
  logic [NUM_GROUPS+MaskW-1:0] fire_pad;
  logic [NUM_GROUPS+MaskW-1:0] zero_pad;

  assign run_tick = (req_i.req_type == pss_pkg::REQ_TICK) && run_enable_i;
  assign set_req  = (req_i.req_type == pss_pkg::REQ_SET_PERIOD) ||
                    (req_i.req_type == pss_pkg::REQ_SET_ACTIVE);
  assign group_ok = (32'(req_i.group) < NUM_GROUPS);
  assign step_inc = step_q + 1'b1;

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
    logic             sel;
    logic             hit;
    logic             want;
    logic [StepW-1:0] shifted;

    assign sel  = set_req && group_ok && (32'(req_i.group) == 32'(g));
    assign hit  = active_q[g] && (next_q[g] == step_q);
    assign want = (req_i.value != '0);
    // Period change moves the next fire step by the difference, modulo 2^32.
    assign shifted = next_q[g] + ({1'b0, req_i.value} - {1'b0, period_q[g]});

    always_comb begin
      active_d[g] = active_q[g];
      period_d[g] = period_q[g];
      next_d[g]   = next_q[g];
      fire_v[g]   = 1'b0;
      zero_v[g]   = 1'b0;
      if (run_tick && hit) begin
        if (period_q[g] == '0) begin
          zero_v[g] = 1'b1;
        end else begin
          fire_v[g] = 1'b1;
          next_d[g] = next_q[g] + {1'b0, period_q[g]};
        end
      end else if (sel && (req_i.req_type == pss_pkg::REQ_SET_PERIOD)) begin
        period_d[g] = req_i.value;
        next_d[g]   = (shifted <= step_q) ? step_inc : shifted;
      end else if (sel && (want != active_q[g])) begin
        if (want) begin
          if (period_q[g] == '0) begin
            zero_v[g] = 1'b1;
          end else begin
            active_d[g] = 1'b1;
            next_d[g]   = step_inc;
          end
        end else begin
          active_d[g] = 1'b0;
        end
      end
    end
  end

  assign step_d = run_tick ? step_inc : step_q;

  // Only the first three groups have a bit in the result masks.
  assign fire_pad = {{MaskW{1'b0}}, fire_v};
  assign zero_pad = {{MaskW{1'b0}}, zero_v};

  assign res_o.fire_mask        = fire_pad[MaskW-1:0];
  assign res_o.zero_period_mask = zero_pad[MaskW-1:0];
  assign res_o.bad_group        = set_req && !group_ok;
  assign res_o.step_mark        = run_tick && (step_q[pss_pkg::StepMarkW-1:0] != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      step_q   <= '0;
      for (int i = 0; i < NUM_GROUPS; i++) begin
        period_q[i] <= '0;
        next_q[i]   <= '0;
      end
    end else if (commit_i) begin
      active_q <= active_d;
      step_q   <= step_d;
      for (int i = 0; i < NUM_GROUPS; i++) begin
        period_q[i] <= period_d[i];
        next_q[i]   <= next_d[i];
      end
    end
  end

endmodule
